/* sv/item_pair_count_store_defines.svh */
// ----------------------------------------------------------------------------
// Pair counter store assertion macros
// Concurrent assertion helpers; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ITEM_PAIR_COUNT_STORE_DEFINES_SVH
`define ITEM_PAIR_COUNT_STORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define IPCS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication.
`define IPCS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define IPCS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define IPCS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

/* sv/ipcs_pkg.sv */
// ----------------------------------------------------------------------------
// Pair counter store package
// Shared widths, status and mode codes, queue flags and state types.
// ----------------------------------------------------------------------------
package ipcs_pkg;

   localparam int ITEMS_DEFAULT = 64;
   localparam int QUEUE_DEPTH   = 2;

   localparam int ITEM_W   = 10;
   localparam int AMOUNT_W = 16;
   localparam int COUNT_W  = 32;
   localparam int STATUS_W = 2;

   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EQUAL = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

   localparam logic MODE_ADD  = 1'b0;
   localparam logic MODE_READ = 1'b1;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_flags_type;

   typedef enum logic [2:0] {
      BK_CLEAR  = 3'b001,
      BK_IDLE   = 3'b010,
      BK_MODIFY = 3'b100
   } back_state_type;

   // Number of counters in the triangular store for a given item count.
   function automatic int store_depth(input int items);
      return items * (items + 2) - 1;
   endfunction

endpackage

/* sv/ipcs_queue.sv */
// ----------------------------------------------------------------------------
// Pair counter store queue
// Small first-in first-out buffer with push/pop handshake and flags.
// ----------------------------------------------------------------------------
module ipcs_queue
   import ipcs_pkg::*;
#(
   parameter int WIDTH = 1,
   parameter int DEPTH = QUEUE_DEPTH,
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output queue_flags_type  flags
);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign flags.full  = (count_ff == CNT_W'(DEPTH));
   assign flags.empty = (count_ff == '0);
   assign do_push     = push & ~flags.full;
   assign do_pop      = pop & ~flags.empty;
   assign pop_data    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* sv/ipcs_front.sv */
// ----------------------------------------------------------------------------
// Pair counter store front end
// Accepts request words, checks the item numbers and computes the store slot.
// ----------------------------------------------------------------------------
module ipcs_front
   import ipcs_pkg::*;
#(
   parameter int ITEMS = ITEMS_DEFAULT,
   localparam int IDX_W = $clog2(store_depth(ITEMS)),
   localparam int OP_W  = 1 + STATUS_W + AMOUNT_W + IDX_W
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                clearing,
   input  logic                req_push,
   output logic                req_full,
   input  logic                req_mode,
   input  logic [ITEM_W-1:0]   req_item_first,
   input  logic [ITEM_W-1:0]   req_item_second,
   input  logic [AMOUNT_W-1:0] req_amount,
   output logic                op_push,
   output logic [OP_W-1:0]     op_data,
   input  queue_flags_type     op_flags
);

   localparam int IW   = (ITEMS > 1) ? $clog2(ITEMS) : 1;
   localparam int SQ_W = 2 * IW + 2;
   localparam logic [ITEM_W:0] LIMIT = (ITEM_W + 1)'(ITEMS);

   logic                fr_valid_ff, fr_valid_in;
   logic [OP_W-1:0]     fr_op_ff;
   logic                accept, move;
   logic                in_range;
   logic [IW-1:0]       first_lo, second_lo, smaller;
   logic [IW:0]         pair_sum;
   logic [SQ_W-1:0]     square, slot_full;
   logic [STATUS_W-1:0] status;

   assign req_full = clearing | (fr_valid_ff & op_flags.full);
   assign accept   = req_push & ~req_full;
   assign move     = fr_valid_ff & ~op_flags.full;
   assign op_push  = move;
   assign op_data  = fr_op_ff;

   // Slot of pair {a, b}: floor((a+b)^2 / 4) plus the smaller item.
   always_comb begin
      in_range  = ({1'b0, req_item_first} < LIMIT) && ({1'b0, req_item_second} < LIMIT);
      first_lo  = req_item_first[IW-1:0];
      second_lo = req_item_second[IW-1:0];
      smaller   = (first_lo < second_lo) ? first_lo : second_lo;
      pair_sum  = {1'b0, first_lo} + {1'b0, second_lo};
      square    = SQ_W'(pair_sum) * SQ_W'(pair_sum);
      slot_full = (square >> 2) + SQ_W'(smaller);
      if (!in_range) begin
         status = ST_RANGE;
      end else if (req_item_first == req_item_second) begin
         status = ST_EQUAL;
      end else begin
         status = ST_DONE;
      end
      fr_valid_in = accept | (fr_valid_ff & ~move);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fr_valid_ff <= 1'b0;
      end else begin
         fr_valid_ff <= fr_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         fr_op_ff <= {req_mode, status, req_amount, slot_full[IDX_W-1:0]};
      end
   end

endmodule

/* sv/ipcs_back.sv */
// ----------------------------------------------------------------------------
// Pair counter store back end
// Owns the counter memory: clears it after reset, then runs read-modify-write.
// ----------------------------------------------------------------------------
module ipcs_back
   import ipcs_pkg::*;
#(
   parameter int ITEMS = ITEMS_DEFAULT,
   localparam int DEPTH = store_depth(ITEMS),
   localparam int IDX_W = $clog2(DEPTH),
   localparam int OP_W  = 1 + STATUS_W + AMOUNT_W + IDX_W,
   localparam int RES_W = STATUS_W + COUNT_W
) (
   input  logic             clock,
   input  logic             reset,
   output logic             clearing,
   input  logic [OP_W-1:0]  op_data,
   input  queue_flags_type  op_flags,
   output logic             op_pop,
   output logic             res_push,
   output logic [RES_W-1:0] res_data,
   input  queue_flags_type  res_flags
);

   localparam int MODE_POS   = OP_W - 1;
   localparam int STATUS_LSB = AMOUNT_W + IDX_W;
   localparam int AMOUNT_LSB = IDX_W;

   logic [COUNT_W-1:0] mem [DEPTH];

   back_state_type     state_ff, state_in;
   logic [IDX_W-1:0]   clr_ff, clr_in;
   logic [OP_W-1:0]    op_ff, op_in;
   logic [COUNT_W-1:0] rd_ff;
   logic               mem_we;
   logic [IDX_W-1:0]   mem_addr;
   logic [COUNT_W-1:0] mem_wdata;
   logic               op_mode;
   logic [STATUS_W-1:0] op_status;
   logic [AMOUNT_W-1:0] op_amount;
   logic [COUNT_W:0]   raw_sum;
   logic [COUNT_W-1:0] sat_sum, count;

   assign clearing  = (state_ff == BK_CLEAR);
   assign op_mode   = op_ff[MODE_POS];
   assign op_status = op_ff[STATUS_LSB +: STATUS_W];
   assign op_amount = op_ff[AMOUNT_LSB +: AMOUNT_W];
   assign raw_sum   = {1'b0, rd_ff} + (COUNT_W + 1)'(op_amount);
   assign sat_sum   = raw_sum[COUNT_W] ? COUNT_MAX : raw_sum[COUNT_W-1:0];
   assign res_data  = {op_status, count};

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      op_in     = op_ff;
      op_pop    = 1'b0;
      res_push  = 1'b0;
      mem_we    = 1'b0;
      mem_addr  = op_ff[IDX_W-1:0];
      mem_wdata = sat_sum;
      count     = '0;
      case (state_ff)
         BK_CLEAR: begin
            mem_we    = 1'b1;
            mem_addr  = clr_ff;
            mem_wdata = '0;
            if (clr_ff == IDX_W'(DEPTH - 1)) begin
               state_in = BK_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         BK_IDLE: begin
            mem_addr = op_data[IDX_W-1:0];
            if (!op_flags.empty && !res_flags.full) begin
               op_pop   = 1'b1;
               op_in    = op_data;
               state_in = BK_MODIFY;
            end
         end
         BK_MODIFY: begin
            res_push = 1'b1;
            state_in = BK_IDLE;
            if (op_status == ST_DONE) begin
               if (op_mode == MODE_ADD) begin
                  mem_we = 1'b1;
                  count  = sat_sum;
               end else begin
                  count = rd_ff;
               end
            end
         end
         default: begin
            state_in = BK_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      rd_ff <= mem[mem_addr];
   end

endmodule

/* sv/item_pair_count_store.sv */
// ----------------------------------------------------------------------------
// Item pair count store
// One saturating 32-bit counter per unordered pair of distinct item numbers.
// ----------------------------------------------------------------------------
// Usage: request words enter through a queue-like port (req_push, req_full).
// Each word either adds req_amount to the counter of the pair
// {req_item_first, req_item_second} or reads that counter. Every word gives
// exactly one response word, in order, on a second queue-like port
// (rsp_empty, rsp_pop): the status and the counter value after the add or
// the value read. Out-of-range items and equal items give a nonzero status
// and a zero count, and leave the store untouched.
// The back end handles each word in two states, a read in BK_IDLE and then a
// write in BK_MODIFY of the single-port counter memory, so it takes no new
// word before it is through with the last. After reset the memory is swept
// to zero, one counter a cycle, over ITEMS*(ITEMS+2)-1 counters (4223 at 64
// items); req_full stays high while the sweep runs. When the receiver stops
// popping, the response queue and then the request queue fill, and req_full
// rises; nothing is dropped.
// ----------------------------------------------------------------------------
`include "item_pair_count_store_defines.svh"

module item_pair_count_store
   import ipcs_pkg::*;
#(
   parameter int ITEMS = ITEMS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  logic                req_mode,
   input  logic [ITEM_W-1:0]   req_item_first,
   input  logic [ITEM_W-1:0]   req_item_second,
   input  logic [AMOUNT_W-1:0] req_amount,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [COUNT_W-1:0]  rsp_pair_count
);

   localparam int IDX_W = $clog2(store_depth(ITEMS));
   localparam int OP_W  = 1 + STATUS_W + AMOUNT_W + IDX_W;
   localparam int RES_W = STATUS_W + COUNT_W;

   // Classified words travel from the front end to the back end here.
   logic            op_push, op_pop;
   logic [OP_W-1:0] op_in_data, op_out_data;
   queue_flags_type op_flags;

   // Finished response words wait here until the receiver pops them.
   logic             res_push;
   logic [RES_W-1:0] res_in_data, res_out_data;
   queue_flags_type  res_flags;

   logic clearing;

   ipcs_front #(
      .ITEMS(ITEMS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .clearing       (clearing),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_mode       (req_mode),
      .req_item_first (req_item_first),
      .req_item_second(req_item_second),
      .req_amount     (req_amount),
      .op_push        (op_push),
      .op_data        (op_in_data),
      .op_flags       (op_flags)
   );

   ipcs_queue #(
      .WIDTH(OP_W),
      .DEPTH(QUEUE_DEPTH)
   ) u_op_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (op_push),
      .push_data(op_in_data),
      .pop      (op_pop),
      .pop_data (op_out_data),
      .flags    (op_flags)
   );

   ipcs_back #(
      .ITEMS(ITEMS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .clearing (clearing),
      .op_data  (op_out_data),
      .op_flags (op_flags),
      .op_pop   (op_pop),
      .res_push (res_push),
      .res_data (res_in_data),
      .res_flags(res_flags)
   );

   ipcs_queue #(
      .WIDTH(RES_W),
      .DEPTH(QUEUE_DEPTH)
   ) u_res_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (res_push),
      .push_data(res_in_data),
      .pop      (rsp_pop),
      .pop_data (res_out_data),
      .flags    (res_flags)
   );

   assign rsp_empty      = res_flags.empty;
   assign rsp_status     = res_out_data[RES_W-1 -: STATUS_W];
   assign rsp_pair_count = res_out_data[COUNT_W-1:0];

   // No request word may enter while the memory is being swept.
   `IPCS_ASSERT_IMP(a_no_accept_clearing, clock, reset, clearing, req_full, "word accepted during clear")
   // A rejected word always reports a zero count.
   `IPCS_ASSERT_IMP(a_reject_zero, clock, reset, !rsp_empty && rsp_status != ST_DONE, rsp_pair_count == '0, "rejected word with nonzero count")
   // The back end never writes a response into a full response queue.
   `IPCS_ASSERT_IMP(a_res_room, clock, reset, res_push, !res_flags.full, "response queue overflow")
   // The clear sweep starts right after reset.
   `IPCS_ASSERT_IMP(a_clear_after_reset, clock, reset, $fell(reset), clearing, "no clear after reset")

endmodule
